[hdl/whmf_pkg.sv]
package whmf_pkg;

  // Default stack capacity, handed to the top level as its parameter default.
  localparam int MAX_WINDOWS_DEF = 16;

  localparam int COORD_W  = 12;
  localparam int NUMBER_W = 7;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLICK = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
  } rect_t;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COORD_W-1:0] far_x;
    logic [COORD_W-1:0] far_y;
  } in_item_t;

  typedef struct packed {
    logic                selected;
    logic [NUMBER_W-1:0] window_number;
  } out_item_t;

endpackage

[hdl/whmf_rect_mem.sv]
module whmf_rect_mem
  import whmf_pkg::*;
#(
  parameter int DEPTH  = MAX_WINDOWS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  rect_t              wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  input  logic [COORD_W-1:0] pt_x,
  input  logic [COORD_W-1:0] pt_y,
  output logic               hit
);

  rect_t store_r [DEPTH];
  rect_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  // Edges count as inside; an inverted rectangle can never contain a point.
  assign hit = (pt_x >= rdata_r.left) && (pt_x <= rdata_r.right) &&
               (pt_y >= rdata_r.bottom) && (pt_y <= rdata_r.top);

endmodule

[hdl/whmf_order_mem.sv]
module whmf_order_mem
  import whmf_pkg::*;
#(
  parameter int DEPTH  = MAX_WINDOWS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ADDR_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [ADDR_W-1:0] rdata
);

  // Each entry holds the slot index of the window at that stack position.
  logic [ADDR_W-1:0] store_r [DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/window_hit_move_to_front_top.sv]
// Channel   Ports                            Moves
// -------   ------------------------------   --------------------------------------
// input     in_valid, in_ready, in_data      one load or click item (in_item_t)
// result    out_valid, out_ready, out_data   one result item per click (out_item_t)
//
// A load moves every stored window down one stack position and then writes its own slot
// at the top (position 0). A click compares the windows from the top down; on a hit it
// moves the hit window to the top before raising its result, and a click that misses all
// windows raises a result with selected low. Reset: rst_n (synchronous, active low)
// empties the stack and clears the handshakes. Stalls: a finished result waits in the
// output register while the next item is taken; only a second click stalls at its end.
module window_hit_move_to_front_top
  import whmf_pkg::*;
#(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // A slot index addresses both memories; the count must also hold MAX_WINDOWS.
  localparam int SLOT_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_FRONT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state_r,    state_nxt;
  logic [CNT_W-1:0]   count_r,    count_nxt;
  logic [COORD_W-1:0] px_r,       px_nxt;
  logic [COORD_W-1:0] py_r,       py_nxt;
  logic               click_r,    click_nxt;
  logic               hit_r,      hit_nxt;
  logic [SLOT_W-1:0]  slot_r,     slot_nxt;

  // Search pipeline: issue an order read, then a rectangle read, then compare.
  logic [CNT_W-1:0]   rd_pos_r,   rd_pos_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic [CNT_W-1:0]   s1_pos_r,   s1_pos_nxt;
  logic               s2_valid_r, s2_valid_nxt;
  logic [CNT_W-1:0]   s2_pos_r,   s2_pos_nxt;
  logic [SLOT_W-1:0]  s2_slot_r,  s2_slot_nxt;

  // Shift walk: read position j-1, write it back one position lower next cycle.
  logic [CNT_W-1:0]   sh_rd_r,    sh_rd_nxt;
  logic               sh_issue_r, sh_issue_nxt;
  logic               wb_valid_r, wb_valid_nxt;
  logic [SLOT_W-1:0]  wb_addr_r,  wb_addr_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r,  out_data_nxt;

  logic               in_fire;
  logic               full;
  logic               rect_we;
  rect_t              rect_wdata;
  logic               rect_re;
  logic [SLOT_W-1:0]  rect_raddr;
  logic               rect_hit;
  logic               order_we;
  logic [SLOT_W-1:0]  order_waddr;
  logic [SLOT_W-1:0]  order_wdata;
  logic               order_re;
  logic [SLOT_W-1:0]  order_raddr;
  logic [SLOT_W-1:0]  order_rdata;
  logic               scan_issue;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign full      = (count_r >= CNT_W'(MAX_WINDOWS));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A load writes its rectangle into the slot named by the current count,
  // in the very cycle that it is accepted. A load beyond capacity is dropped.
  assign rect_we    = in_fire && (in_data.operation == OP_LOAD) && !full;
  assign rect_wdata = '{left:   in_data.point_x,
                        bottom: in_data.point_y,
                        right:  in_data.far_x,
                        top:    in_data.far_y};
  assign rect_re    = (state_r == ST_SCAN) && s1_valid_r;
  assign rect_raddr = order_rdata;

  assign scan_issue = (state_r == ST_SCAN) && (rd_pos_r < count_r);

  whmf_rect_mem #(
    .DEPTH  (MAX_WINDOWS),
    .ADDR_W (SLOT_W)
  ) u_rect_mem (
    .clk   (clk),
    .we    (rect_we),
    .waddr (count_r[SLOT_W-1:0]),
    .wdata (rect_wdata),
    .re    (rect_re),
    .raddr (rect_raddr),
    .pt_x  (px_r),
    .pt_y  (py_r),
    .hit   (rect_hit)
  );

  whmf_order_mem #(
    .DEPTH  (MAX_WINDOWS),
    .ADDR_W (SLOT_W)
  ) u_order_mem (
    .clk   (clk),
    .we    (order_we),
    .waddr (order_waddr),
    .wdata (order_wdata),
    .re    (order_re),
    .raddr (order_raddr),
    .rdata (order_rdata)
  );

  // The order memory's ports are shared between the search, the shift walk
  // and the final write of the chosen slot to the top; the sequencer states
  // keep them apart. During the walk the write lands two positions below the
  // read issued in the same cycle, so no forwarding is needed.
  always_comb begin
    order_re    = 1'b0;
    order_raddr = '0;
    order_we    = 1'b0;
    order_waddr = '0;
    order_wdata = '0;
    case (state_r)
      ST_SCAN: begin
        order_re    = scan_issue;
        order_raddr = rd_pos_r[SLOT_W-1:0];
      end
      ST_SHIFT: begin
        order_re    = sh_issue_r;
        order_raddr = sh_rd_r[SLOT_W-1:0];
        order_we    = wb_valid_r;
        order_waddr = wb_addr_r;
        order_wdata = order_rdata;
      end
      ST_FRONT: begin
        order_we    = 1'b1;
        order_waddr = '0;
        order_wdata = slot_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    click_nxt     = click_r;
    hit_nxt       = hit_r;
    slot_nxt      = slot_r;
    rd_pos_nxt    = rd_pos_r;
    s1_valid_nxt  = s1_valid_r;
    s1_pos_nxt    = s1_pos_r;
    s2_valid_nxt  = s2_valid_r;
    s2_pos_nxt    = s2_pos_r;
    s2_slot_nxt   = s2_slot_r;
    sh_rd_nxt     = sh_rd_r;
    sh_issue_nxt  = sh_issue_r;
    wb_valid_nxt  = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          px_nxt = in_data.point_x;
          py_nxt = in_data.point_y;
          if (in_data.operation == OP_CLICK) begin
            click_nxt    = 1'b1;
            rd_pos_nxt   = '0;
            s1_valid_nxt = 1'b0;
            s2_valid_nxt = 1'b0;
            state_nxt    = ST_SCAN;
          end else if (!full) begin
            // The new window goes on top: every position below the count
            // moves down by one, then the new slot is written at the top.
            click_nxt    = 1'b0;
            slot_nxt     = count_r[SLOT_W-1:0];
            if (count_r == '0) begin
              state_nxt = ST_FRONT;
            end else begin
              sh_rd_nxt    = count_r - CNT_W'(1);
              sh_issue_nxt = 1'b1;
              state_nxt    = ST_SHIFT;
            end
          end
        end
      end

      ST_SCAN: begin
        rd_pos_nxt   = rd_pos_r + CNT_W'(scan_issue);
        s1_valid_nxt = scan_issue;
        s1_pos_nxt   = rd_pos_r;
        s2_valid_nxt = s1_valid_r;
        s2_pos_nxt   = s1_pos_r;
        s2_slot_nxt  = order_rdata;
        if (s2_valid_r && rect_hit) begin
          // First hit from the top wins; reads already in flight are dropped.
          hit_nxt      = 1'b1;
          slot_nxt     = s2_slot_r;
          s1_valid_nxt = 1'b0;
          s2_valid_nxt = 1'b0;
          if (s2_pos_r == '0) begin
            state_nxt = ST_FRONT;
          end else begin
            sh_rd_nxt    = s2_pos_r - CNT_W'(1);
            sh_issue_nxt = 1'b1;
            state_nxt    = ST_SHIFT;
          end
        end else if ((rd_pos_r == count_r) && !s1_valid_r) begin
          // Every stored window has been compared without a hit.
          hit_nxt      = 1'b0;
          s2_valid_nxt = 1'b0;
          state_nxt    = ST_DONE;
        end
      end

      ST_SHIFT: begin
        wb_valid_nxt = sh_issue_r;
        wb_addr_nxt  = sh_rd_r[SLOT_W-1:0] + SLOT_W'(1);
        if (sh_issue_r) begin
          if (sh_rd_r == '0) begin
            sh_issue_nxt = 1'b0;
          end else begin
            sh_rd_nxt = sh_rd_r - CNT_W'(1);
          end
        end else begin
          // The last move is written back in this cycle.
          state_nxt = ST_FRONT;
        end
      end

      ST_FRONT: begin
        if (click_r) begin
          state_nxt = ST_DONE;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_IDLE;
        end
      end

      ST_DONE: begin
        // Wait here only if an earlier result has still not been taken.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.selected       = hit_r;
          out_data_nxt.window_number  = hit_r ?
            (NUMBER_W'(slot_r) + NUMBER_W'(1)) : '0;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      sh_issue_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      sh_issue_r  <= sh_issue_nxt;
      wb_valid_r  <= wb_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    click_r    <= click_nxt;
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    rd_pos_r   <= rd_pos_nxt;
    s1_pos_r   <= s1_pos_nxt;
    s2_pos_r   <= s2_pos_nxt;
    s2_slot_r  <= s2_slot_nxt;
    sh_rd_r    <= sh_rd_nxt;
    wb_addr_r  <= wb_addr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
